### design/block_mapping_ftl_defines.svh
// Assertion macros shared by the block-mapped flash translation RTL.
`ifndef BLOCK_MAPPING_FTL_DEFINES_SVH
`define BLOCK_MAPPING_FTL_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define BMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bmf_pkg.sv
// Shared types and codes of the block-mapped flash translation block.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;

  // Widest block index and page offset the block supports.
  localparam int BLK_W = 10;
  localparam int OFF_W = 6;
  localparam int LSN_W = 11;
  localparam int PG_W  = 11;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ACK   = 3'd0,
    OP_READ  = 3'd1,
    OP_HDR   = 3'd2,
    OP_DATA  = 3'd3,
    OP_COPY  = 3'd4,
    OP_ERASE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_ONE   = 2'd0,
    JOB_ALLOC = 2'd1,
    JOB_COPY  = 2'd2
  } job_kind_t;

  // One unit of flash work handed from the front to the back.
  typedef struct packed {
    job_kind_t          kind;
    op_t                op;
    status_t            status;
    logic [BLK_W-1:0]   blk;
    logic [BLK_W-1:0]   src_blk;
    logic [OFF_W-1:0]   off;
    logic [BLK_W-1:0]   lbn;
    logic [LSN_W-1:0]   lsn;
  } job_t;

endpackage
`default_nettype wire

### design/block_mapping_ftl.sv
// Top level of the block-mapped flash translation block.
//
// Takes one command word at a time: a read or write of a logical sector, or a
// mount-scan report of one physical block, and answers with a run of flash
// command words ending in tlast. The front end holds the block map and the
// written-page memory and is ready again once it has pushed the job for a
// word, which a full job queue can hold off; a write that must allocate
// first runs a free-block search that looks at one block per cycle. The back
// end emits one word per cycle from a two-entry job queue while the output is
// ready, so an overwrite's PAGES_IN_BLOCK + 1 words drain at the output while
// the front moves on. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "block_mapping_ftl_defines.svh"
module block_mapping_ftl #(
  parameter int NUM_BLOCKS     = 64,
  parameter int PAGES_IN_BLOCK = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // logical_sector[10:0], scan_block[16:11], scan_spare_lbn[23:17],
  // scan_written_mask[55:24]
  input  wire logic [55:0]  in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // page_addr[10:0], source_page[21:11], erase_block[27:22], tag_lbn[33:28],
  // tag_lsn[44:34], zero[47:45]
  output logic [47:0]       out_tdata,
  // op[2:0], status[4:3]
  output logic [4:0]        out_tuser,
  output logic              out_tlast
);

  bmf_pkg::job_t     f_job, q_head;
  logic              q_push, q_full, q_valid, q_pop;
  bmf_pkg::op_t      o_op;
  bmf_pkg::status_t  o_status;
  logic [10:0]       o_page, o_src, o_lsn;
  logic [5:0]        o_erase, o_lbn;

  bmf_front #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .PAGES_IN_BLOCK (PAGES_IN_BLOCK)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_cmd        (in_tuser),
    .in_lsn        (in_tdata[10:0]),
    .in_scan_block (in_tdata[16:11]),
    .in_scan_tag   (in_tdata[23:17]),
    .in_scan_mask  (in_tdata[55:24]),
    .job_o         (f_job),
    .push_o        (q_push),
    .q_full_i      (q_full)
  );

  bmf_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (f_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  bmf_back #(
    .PAGES_IN_BLOCK (PAGES_IN_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_op      (o_op),
    .out_page    (o_page),
    .out_src     (o_src),
    .out_erase   (o_erase),
    .out_tag_lbn (o_lbn),
    .out_tag_lsn (o_lsn),
    .out_status  (o_status),
    .out_last    (out_tlast)
  );

  // Pack the command word
  assign out_tdata = {3'b000, o_lsn, o_lbn, o_erase, o_src, o_page};
  assign out_tuser = {o_status, o_op};

  `BMF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
                   "front took a second word without classifying the first")
  `BMF_ASSERT_NOW(a_no_push_when_full, q_push, !q_full,
                  "job pushed into a full queue")
  `BMF_ASSERT_NOW(a_erase_not_last, out_tvalid && (out_tuser[2:0] == bmf_pkg::OP_ERASE),
                  !out_tlast, "erase ended a run")
  `BMF_ASSERT_NOW(a_error_is_ack, out_tvalid && (out_tuser[4:3] != bmf_pkg::ST_OK),
                  (out_tuser[2:0] == bmf_pkg::OP_ACK) && out_tlast,
                  "error status on a flash command word")

endmodule
`default_nettype wire

### design/bmf_front.sv
// Front end: accepts words, translates sectors, keeps the map and emits jobs.
`timescale 1ns / 1ps
`default_nettype none
module bmf_front #(
  parameter int NUM_BLOCKS     = 64,
  parameter int PAGES_IN_BLOCK = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [10:0]          in_lsn,
  input  wire logic [5:0]           in_scan_block,
  input  wire logic [6:0]           in_scan_tag,
  input  wire logic [31:0]          in_scan_mask,
  output bmf_pkg::job_t             job_o,
  output logic                      push_o,
  input  wire logic                 q_full_i
);

  localparam int BW          = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int DATA_BLOCKS = NUM_BLOCKS - 1;
  localparam int MAW         = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
  localparam int PW          = $clog2(PAGES_IN_BLOCK);
  localparam int P           = PAGES_IN_BLOCK;
  localparam int RECIP       = 65536 / PAGES_IN_BLOCK;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FIX, S_LOOK, S_MAP, S_SRCH, S_PWWAIT, S_PW
  } state_t;

  state_t               state_r, state_nxt;
  bmf_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [10:0]          lsn_r, lsn_nxt;
  logic [5:0]           sblk_r, sblk_nxt;
  logic [6:0]           stag_r, stag_nxt;
  logic [31:0]          smask_r, smask_nxt;
  logic [26:0]          prod_r, prod_nxt;
  logic [10:0]          lbn_r, lbn_nxt;
  logic [PW-1:0]        off_r, off_nxt;
  logic [BW-1:0]        idx_r, idx_nxt;
  logic [BW-1:0]        pbn_r, pbn_nxt;
  logic [BW-1:0]        pwa_r, pwa_nxt;
  logic                 amode_r, amode_nxt;
  logic [DATA_BLOCKS-1:0] map_vld_r, map_vld_nxt;
  logic [NUM_BLOCKS-1:0]  pw_vld_r, pw_vld_nxt;
  logic [NUM_BLOCKS-1:0]  alloc_r, alloc_nxt;
  logic [BW-1:0]        spare_r, spare_nxt;
  logic                 spare_found_r, spare_found_nxt;

  // Memories and their registered read data
  logic [BW-1:0]        map_mem [DATA_BLOCKS];
  logic [P-1:0]         pw_mem  [NUM_BLOCKS];
  logic [BW-1:0]        map_q_r;
  logic [P-1:0]         pw_row_r;

  logic                 map_we;
  logic [MAW-1:0]       map_wa;
  logic [BW-1:0]        map_wd;
  logic                 pw_we;
  logic [BW-1:0]        pw_wa;
  logic [P-1:0]         pw_wd;

  // Sector split helpers
  logic [10:0]          q_est, r_est, q_fix, r_fix;
  logic [16:0]          qp;
  logic                 q_corr;
  logic [63:0]          mask64;
  logic [P-1:0]         page_bit;
  logic                 sf_base;
  logic                 blk_free;
  logic                 map_hit;

  assign in_ready = (state_r == S_IDLE);

  // Finish the reciprocal divide with one correction step
  assign q_est    = prod_r[26:16];
  assign qp       = 17'(q_est) * 17'(P);
  assign r_est    = lsn_r - qp[10:0];
  assign q_corr   = (r_est >= 11'(P));
  assign q_fix    = q_corr ? q_est + 11'd1 : q_est;
  assign r_fix    = q_corr ? r_est - 11'(P) : r_est;
  assign mask64   = {32'd0, smask_r};
  assign page_bit = {{(P-1){1'b0}}, 1'b1} << off_r;
  assign blk_free = !alloc_r[idx_r] && !(spare_found_r && (idx_r == spare_r));
  assign map_hit  = map_vld_r[MAW'(lbn_r)];

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    lsn_nxt         = lsn_r;
    sblk_nxt        = sblk_r;
    stag_nxt        = stag_r;
    smask_nxt       = smask_r;
    prod_nxt        = prod_r;
    lbn_nxt         = lbn_r;
    off_nxt         = off_r;
    idx_nxt         = idx_r;
    pbn_nxt         = pbn_r;
    pwa_nxt         = pwa_r;
    amode_nxt       = amode_r;
    map_vld_nxt     = map_vld_r;
    pw_vld_nxt      = pw_vld_r;
    alloc_nxt       = alloc_r;
    spare_nxt       = spare_r;
    spare_found_nxt = spare_found_r;
    sf_base         = spare_found_r;
    map_we          = 1'b0;
    map_wa          = MAW'(lbn_r);
    map_wd          = pbn_r;
    pw_we           = 1'b0;
    pw_wa           = pbn_r;
    pw_wd           = pw_row_r | page_bit;
    job_o           = '0;
    push_o          = 1'b0;

    case (state_r)
      // Take a word
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = bmf_pkg::cmd_t'(in_cmd);
          lsn_nxt   = in_lsn;
          sblk_nxt  = in_scan_block;
          stag_nxt  = in_scan_tag;
          smask_nxt = in_scan_mask;
          state_nxt = S_DIV;
        end
      end
      // Multiply by the reciprocal of the block size
      S_DIV: begin
        prod_nxt  = 27'(lsn_r) * 27'(RECIP);
        state_nxt = S_FIX;
      end
      // Classify; handle scans and trivial cases here
      S_FIX: begin
        lbn_nxt = q_fix;
        off_nxt = PW'(r_fix);
        job_o.kind = bmf_pkg::JOB_ONE;
        job_o.op   = bmf_pkg::OP_ACK;
        case (cmd_r)
          bmf_pkg::CMD_SCAN: begin
            push_o = !q_full_i;
            if (!q_full_i) begin
              if (sblk_r == 6'd0) begin
                map_vld_nxt = '0;
                alloc_nxt   = '0;
                sf_base     = 1'b0;
                spare_found_nxt = 1'b0;
              end
              if (32'(sblk_r) < NUM_BLOCKS) begin
                pw_we  = 1'b1;
                pw_wa  = BW'(sblk_r);
                pw_wd  = mask64[P-1:0];
                pw_vld_nxt[BW'(sblk_r)] = 1'b1;
                if (stag_r == 7'h7F) begin
                  if (!sf_base) begin
                    spare_found_nxt = 1'b1;
                    spare_nxt       = BW'(sblk_r);
                  end
                end else if (!stag_r[6] && (32'(stag_r) < DATA_BLOCKS)) begin
                  map_we = 1'b1;
                  map_wa = MAW'(stag_r);
                  map_wd = BW'(sblk_r);
                  map_vld_nxt[MAW'(stag_r)] = 1'b1;
                  alloc_nxt[BW'(sblk_r)]    = 1'b1;
                end
              end
              state_nxt = S_IDLE;
            end
          end
          bmf_pkg::CMD_READ, bmf_pkg::CMD_WRITE: begin
            if (32'(q_fix) >= DATA_BLOCKS) begin
              job_o.status = (cmd_r == bmf_pkg::CMD_READ) ? bmf_pkg::ST_UNMAPPED
                                                          : bmf_pkg::ST_FULL;
              push_o = !q_full_i;
              if (!q_full_i) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_LOOK;
            end
          end
          default: begin
            push_o = !q_full_i;
            if (!q_full_i) state_nxt = S_IDLE;
          end
        endcase
      end
      // Map entry is being read
      S_LOOK: begin
        state_nxt = S_MAP;
      end
      // Use the map entry
      S_MAP: begin
        if (cmd_r == bmf_pkg::CMD_READ) begin
          job_o.kind = bmf_pkg::JOB_ONE;
          if (map_hit) begin
            job_o.op  = bmf_pkg::OP_READ;
            job_o.blk = bmf_pkg::BLK_W'(map_q_r);
            job_o.off = bmf_pkg::OFF_W'(off_r);
          end else begin
            job_o.op     = bmf_pkg::OP_ACK;
            job_o.status = bmf_pkg::ST_UNMAPPED;
          end
          push_o = !q_full_i;
          if (!q_full_i) state_nxt = S_IDLE;
        end else if (!map_hit) begin
          idx_nxt   = '0;
          state_nxt = S_SRCH;
        end else begin
          pbn_nxt   = map_q_r;
          pwa_nxt   = map_q_r;
          amode_nxt = 1'b0;
          state_nxt = S_PWWAIT;
        end
      end
      // Walk the blocks for the lowest free one
      S_SRCH: begin
        if (blk_free) begin
          pbn_nxt   = idx_r;
          pwa_nxt   = idx_r;
          amode_nxt = 1'b1;
          state_nxt = S_PWWAIT;
        end else if (idx_r == BW'(NUM_BLOCKS - 1)) begin
          job_o.kind   = bmf_pkg::JOB_ONE;
          job_o.op     = bmf_pkg::OP_ACK;
          job_o.status = bmf_pkg::ST_FULL;
          push_o = !q_full_i;
          if (!q_full_i) state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + BW'(1);
        end
      end
      // Written-page row is being read
      S_PWWAIT: begin
        state_nxt = S_PW;
      end
      // Decide between plain program, allocation, overwrite and a full error
      S_PW: begin
        job_o.blk = bmf_pkg::BLK_W'(pbn_r);
        job_o.off = bmf_pkg::OFF_W'(off_r);
        job_o.lbn = bmf_pkg::BLK_W'(lbn_r);
        job_o.lsn = lsn_r;
        push_o    = !q_full_i;
        if (!q_full_i) begin
          state_nxt = S_IDLE;
          if (amode_r) begin
            job_o.kind = bmf_pkg::JOB_ALLOC;
            job_o.op   = bmf_pkg::OP_HDR;
            map_we     = 1'b1;
            map_vld_nxt[MAW'(lbn_r)] = 1'b1;
            alloc_nxt[pbn_r]  = 1'b1;
            pw_we             = 1'b1;
            pw_vld_nxt[pbn_r] = 1'b1;
          end else if (!pw_row_r[off_r]) begin
            job_o.kind = bmf_pkg::JOB_ONE;
            job_o.op   = bmf_pkg::OP_DATA;
            pw_we      = 1'b1;
            pw_vld_nxt[pbn_r] = 1'b1;
          end else if (!spare_found_r || (spare_r == pbn_r)) begin
            job_o        = '0;
            job_o.kind   = bmf_pkg::JOB_ONE;
            job_o.op     = bmf_pkg::OP_ACK;
            job_o.status = bmf_pkg::ST_FULL;
          end else begin
            job_o.kind    = bmf_pkg::JOB_COPY;
            job_o.op      = bmf_pkg::OP_COPY;
            job_o.blk     = bmf_pkg::BLK_W'(spare_r);
            job_o.src_blk = bmf_pkg::BLK_W'(pbn_r);
            map_we        = 1'b1;
            map_wd        = spare_r;
            pw_we         = 1'b1;
            pw_wa         = spare_r;
            pw_wd         = pw_row_r;
            pw_vld_nxt[spare_r] = 1'b1;
            pw_vld_nxt[pbn_r]   = 1'b0;
            alloc_nxt[spare_r]  = 1'b1;
            alloc_nxt[pbn_r]    = 1'b0;
            spare_nxt           = pbn_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      map_vld_r     <= '0;
      pw_vld_r      <= '0;
      alloc_r       <= '0;
      spare_r       <= '0;
      spare_found_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      map_vld_r     <= map_vld_nxt;
      pw_vld_r      <= pw_vld_nxt;
      alloc_r       <= alloc_nxt;
      spare_r       <= spare_nxt;
      spare_found_r <= spare_found_nxt;
    end
    cmd_r   <= cmd_nxt;
    lsn_r   <= lsn_nxt;
    sblk_r  <= sblk_nxt;
    stag_r  <= stag_nxt;
    smask_r <= smask_nxt;
    prod_r  <= prod_nxt;
    lbn_r   <= lbn_nxt;
    off_r   <= off_nxt;
    idx_r   <= idx_nxt;
    pbn_r   <= pbn_nxt;
    pwa_r   <= pwa_nxt;
    amode_r <= amode_nxt;
  end

  // Block map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q_r <= map_mem[MAW'(lbn_r)];
  end

  // Written-page memory; an invalid row reads as all clear
  always_ff @(posedge clk) begin
    if (pw_we) pw_mem[pw_wa] <= pw_wd;
    pw_row_r <= pw_vld_r[pwa_r] ? pw_mem[pwa_r] : '0;
  end

endmodule
`default_nettype wire

### design/bmf_jobq.sv
// Two-entry job queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module bmf_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  bmf_pkg::job_t       job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bmf_pkg::job_t       head_o
);

  bmf_pkg::job_t  ent_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == 2'd2);
  assign valid_o = (cnt_r != 2'd0);
  assign head_o  = ent_r[rp_r];

  // Advance pointers and count
  always_comb begin
    wp_nxt  = push_i ? !wp_r : wp_r;
    rp_nxt  = pop_i ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_i) ent_r[wp_r] <= job_i;
  end

endmodule
`default_nettype wire

### design/bmf_back.sv
// Back end: expands each job into flash command words on the output register.
`timescale 1ns / 1ps
`default_nettype none
module bmf_back #(
  parameter int PAGES_IN_BLOCK = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid_i,
  input  bmf_pkg::job_t      q_head_i,
  output logic               q_pop_o,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bmf_pkg::op_t       out_op,
  output logic [10:0]        out_page,
  output logic [10:0]        out_src,
  output logic [5:0]         out_erase,
  output logic [5:0]         out_tag_lbn,
  output logic [10:0]        out_tag_lsn,
  output bmf_pkg::status_t   out_status,
  output logic               out_last
);

  localparam int P  = PAGES_IN_BLOCK;
  localparam int SW = $clog2(PAGES_IN_BLOCK + 1);

  logic [SW-1:0]      step_r, step_nxt;
  logic               vld_r, vld_nxt;
  bmf_pkg::op_t       op_r, op_nxt;
  logic [10:0]        page_r, page_nxt;
  logic [10:0]        src_r, src_nxt;
  logic [5:0]         erase_r, erase_nxt;
  logic [5:0]         tlbn_r, tlbn_nxt;
  logic [10:0]        tlsn_r, tlsn_nxt;
  bmf_pkg::status_t   status_r, status_nxt;
  logic               last_r, last_nxt;

  logic               load;
  logic [31:0]        cp_idx;
  logic [31:0]        dst_base, src_base;

  assign load     = q_valid_i && (!vld_r || out_ready);
  assign cp_idx   = 32'(step_r) + ((32'(step_r) >= 32'(q_head_i.off)) ? 32'd1 : 32'd0);
  assign dst_base = 32'(q_head_i.blk) * P;
  assign src_base = 32'(q_head_i.src_blk) * P;

  // Build the next command word of the head job
  always_comb begin
    op_nxt     = op_r;
    page_nxt   = page_r;
    src_nxt    = src_r;
    erase_nxt  = erase_r;
    tlbn_nxt   = tlbn_r;
    tlsn_nxt   = tlsn_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    step_nxt   = step_r;
    vld_nxt    = out_ready ? 1'b0 : vld_r;
    q_pop_o    = 1'b0;
    if (load) begin
      vld_nxt    = 1'b1;
      page_nxt   = 11'd0;
      src_nxt    = 11'd0;
      erase_nxt  = 6'd0;
      tlbn_nxt   = 6'd0;
      tlsn_nxt   = 11'd0;
      status_nxt = q_head_i.status;
      last_nxt   = 1'b1;
      op_nxt     = q_head_i.op;
      case (q_head_i.kind)
        bmf_pkg::JOB_ONE: begin
          if (q_head_i.op == bmf_pkg::OP_READ || q_head_i.op == bmf_pkg::OP_DATA) begin
            page_nxt = 11'(dst_base + 32'(q_head_i.off));
          end
          if (q_head_i.op == bmf_pkg::OP_DATA) begin
            tlbn_nxt = 6'(q_head_i.lbn);
            tlsn_nxt = q_head_i.lsn;
          end
        end
        bmf_pkg::JOB_ALLOC: begin
          tlbn_nxt = 6'(q_head_i.lbn);
          if (step_r == SW'(0)) begin
            op_nxt   = bmf_pkg::OP_HDR;
            page_nxt = 11'(dst_base);
            last_nxt = 1'b0;
          end else begin
            op_nxt   = bmf_pkg::OP_DATA;
            page_nxt = 11'(dst_base + 32'(q_head_i.off));
            tlsn_nxt = q_head_i.lsn;
          end
        end
        bmf_pkg::JOB_COPY: begin
          if (32'(step_r) < P - 1) begin
            op_nxt   = bmf_pkg::OP_COPY;
            page_nxt = 11'(dst_base + cp_idx);
            src_nxt  = 11'(src_base + cp_idx);
            last_nxt = 1'b0;
          end else if (32'(step_r) == P - 1) begin
            op_nxt    = bmf_pkg::OP_ERASE;
            erase_nxt = 6'(q_head_i.src_blk);
            last_nxt  = 1'b0;
          end else begin
            op_nxt   = bmf_pkg::OP_DATA;
            page_nxt = 11'(dst_base + 32'(q_head_i.off));
            tlbn_nxt = 6'(q_head_i.lbn);
            tlsn_nxt = q_head_i.lsn;
          end
        end
        default: begin
          op_nxt = bmf_pkg::OP_ACK;
        end
      endcase
      // Drop the job after its final word
      if (last_nxt) begin
        q_pop_o  = 1'b1;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      step_r <= step_nxt;
    end
    op_r     <= op_nxt;
    page_r   <= page_nxt;
    src_r    <= src_nxt;
    erase_r  <= erase_nxt;
    tlbn_r   <= tlbn_nxt;
    tlsn_r   <= tlsn_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid   = vld_r;
  assign out_op      = op_r;
  assign out_page    = page_r;
  assign out_src     = src_r;
  assign out_erase   = erase_r;
  assign out_tag_lbn = tlbn_r;
  assign out_tag_lsn = tlsn_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

endmodule
`default_nettype wire

### tb/sv/block_mapping_ftl_tb.sv
// Self-checking testbench of the block-mapped flash translation block.
`timescale 1ns / 1ps
`default_nettype none

// Predicts flash command words and checks them against the block's output.
class ftl_scoreboard;
  localparam int NBLK = 64;
  localparam int NPG  = 32;
  localparam int NLBN = NBLK - 1;

  typedef struct packed {
    bmf_pkg::op_t     op;
    logic [10:0]      page_addr;
    logic [10:0]      source_page;
    logic [5:0]       erase_block;
    logic [5:0]       tag_lbn;
    logic [10:0]      tag_lsn;
    bmf_pkg::status_t status;
    logic             last;
  } flash_word_t;

  bit          lbn_valid[NLBN];
  logic [5:0]  lbn_phys[NLBN];
  logic [5:0]  spare_blk;
  bit          have_spare;
  bit          allocated[NBLK];
  logic [31:0] written[NBLK];
  flash_word_t pending_words[$];
  int          errors;

  function new();
    errors = 0;
    have_spare = 0;
    spare_blk = '0;
    foreach (lbn_valid[i]) begin
      lbn_valid[i] = 0;
      lbn_phys[i] = '0;
    end
    foreach (allocated[i]) begin
      allocated[i] = 0;
      written[i] = '0;
    end
  endfunction

  function void push_word(bmf_pkg::op_t op, int pg, int src, int er, int tlbn,
                          int tlsn, bmf_pkg::status_t st);
    flash_word_t w;
    w.op = op;
    w.page_addr = pg[10:0];
    w.source_page = src[10:0];
    w.erase_block = er[5:0];
    w.tag_lbn = tlbn[5:0];
    w.tag_lsn = tlsn[10:0];
    w.status = st;
    w.last = 0;
    pending_words.push_back(w);
  endfunction

  // Predict the words one accepted command causes; mark the last one.
  function void note_command(bmf_pkg::cmd_t cmd, logic [55:0] data);
    int lsn, lbn, off, blk, tag, pbn, sp, i;
    lsn = data[10:0];
    lbn = lsn / NPG;
    off = lsn % NPG;
    case (cmd)
      bmf_pkg::CMD_READ: begin
        if (lbn >= NLBN || !lbn_valid[lbn])
          push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_UNMAPPED);
        else
          push_word(bmf_pkg::OP_READ, lbn_phys[lbn] * NPG + off, 0, 0, 0, 0,
                    bmf_pkg::ST_OK);
      end
      bmf_pkg::CMD_WRITE: begin
        if (lbn >= NLBN) begin
          push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_FULL);
        end else if (!lbn_valid[lbn]) begin
          for (i = 0; i < NBLK; i++)
            if (!allocated[i] && !(have_spare && i == spare_blk)) break;
          if (i >= NBLK) begin
            push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_FULL);
          end else begin
            push_word(bmf_pkg::OP_HDR, i * NPG, 0, 0, lbn, 0, bmf_pkg::ST_OK);
            push_word(bmf_pkg::OP_DATA, i * NPG + off, 0, 0, lbn, lsn, bmf_pkg::ST_OK);
            lbn_valid[lbn] = 1;
            lbn_phys[lbn] = i[5:0];
            allocated[i] = 1;
            written[i][off] = 1'b1;
          end
        end else begin
          pbn = lbn_phys[lbn];
          if (!written[pbn][off]) begin
            push_word(bmf_pkg::OP_DATA, pbn * NPG + off, 0, 0, lbn, lsn, bmf_pkg::ST_OK);
            written[pbn][off] = 1'b1;
          end else if (!have_spare || spare_blk == pbn) begin
            push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_FULL);
          end else begin
            // Copy the other pages to the spare, erase, program, swap roles.
            sp = spare_blk;
            for (i = 0; i < NPG; i++)
              if (i != off)
                push_word(bmf_pkg::OP_COPY, sp * NPG + i, pbn * NPG + i, 0, 0, 0,
                          bmf_pkg::ST_OK);
            push_word(bmf_pkg::OP_ERASE, 0, 0, pbn, 0, 0, bmf_pkg::ST_OK);
            push_word(bmf_pkg::OP_DATA, sp * NPG + off, 0, 0, lbn, lsn, bmf_pkg::ST_OK);
            lbn_phys[lbn] = sp[5:0];
            written[sp] = written[pbn];
            written[pbn] = '0;
            allocated[sp] = 1;
            allocated[pbn] = 0;
            spare_blk = pbn[5:0];
          end
        end
      end
      bmf_pkg::CMD_SCAN: begin
        blk = data[16:11];
        tag = data[23:17];
        if (blk == 0) begin
          foreach (lbn_valid[k]) begin
            lbn_valid[k] = 0;
            lbn_phys[k] = '0;
          end
          foreach (allocated[k]) allocated[k] = 0;
          have_spare = 0;
        end
        written[blk] = data[55:24];
        if (tag == 7'h7f) begin
          if (!have_spare) begin
            have_spare = 1;
            spare_blk = blk[5:0];
          end
        end else if (tag < NLBN) begin
          lbn_valid[tag] = 1;
          lbn_phys[tag] = blk[5:0];
          allocated[blk] = 1;
        end
        push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_OK);
      end
      default: push_word(bmf_pkg::OP_ACK, 0, 0, 0, 0, 0, bmf_pkg::ST_OK);
    endcase
    pending_words[$].last = 1;
  endfunction

  // Compare one accepted output word with the oldest prediction.
  function void check_word(logic [47:0] data, logic [4:0] user, logic last);
    flash_word_t exp_w, got;
    got.op = bmf_pkg::op_t'(user[2:0]);
    got.status = bmf_pkg::status_t'(user[4:3]);
    got.page_addr = data[10:0];
    got.source_page = data[21:11];
    got.erase_block = data[27:22];
    got.tag_lbn = data[33:28];
    got.tag_lsn = data[44:34];
    got.last = last;
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual %p", $time, got);
      return;
    end
    exp_w = pending_words.pop_front();
    if (got !== exp_w || data[47:45] !== 3'b000) begin
      errors++;
      $display("%0t: mismatch, expected %p, actual %p (pad %b)", $time, exp_w, got,
               data[47:45]);
    end
  endfunction
endclass

module block_mapping_ftl_tb;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  ftl_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  cycles;

  block_mapping_ftl u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check every accepted output word and randomize the receiver stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one command word, with optional idle cycles in front; valid stays
  // high after acceptance until the next word or an idle cycle replaces it.
  task automatic send_word(bmf_pkg::cmd_t cmd, logic [10:0] lsn, logic [5:0] blk,
                           logic [6:0] tag, logic [31:0] mask);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {mask, tag, blk, lsn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, {mask, tag, blk, lsn});
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Rebuild the map: block 0 first, some blocks tagged, others marked spare or given random tags.
  task automatic mount_scan(int nmapped);
    int b;
    logic [6:0] tag;
    for (b = 0; b < 24; b++) begin
      if (b < nmapped && $urandom_range(3) != 0) tag = 7'($urandom_range(62));
      else if ($urandom_range(2) == 0) tag = 7'h7f;
      else tag = 7'($urandom_range(127));
      send_word(bmf_pkg::CMD_SCAN, 11'($urandom), 6'(b), tag, $urandom);
    end
  endtask

  task automatic random_traffic(int n, int hot_lbn);
    int k, c;
    logic [10:0] lsn;
    for (k = 0; k < n; k++) begin
      c = $urandom_range(99);
      if ($urandom_range(9) < 8) lsn = 11'($urandom_range(hot_lbn) * 32 + $urandom_range(31));
      else lsn = 11'($urandom);
      if (c < 40) send_word(bmf_pkg::CMD_READ, lsn, 6'($urandom), 7'($urandom), $urandom);
      else if (c < 90) send_word(bmf_pkg::CMD_WRITE, lsn, 6'($urandom), 7'($urandom), $urandom);
      else if (c < 97) send_word(bmf_pkg::CMD_SCAN, 11'($urandom), 6'($urandom_range(1, 63)),
                                 7'($urandom), $urandom);
      else send_word(bmf_pkg::CMD_NOP, lsn, 6'($urandom), 7'($urandom), $urandom);
    end
  endtask

  initial begin
    int ph;
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = bmf_pkg::CMD_READ;
    out_tready = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: edges of each field and each special case.
    send_word(bmf_pkg::CMD_READ, 11'd0, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_READ, 11'd2047, 6'd63, 7'h3f, 32'hffffffff);
    send_word(bmf_pkg::CMD_WRITE, 11'd2047, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd2016, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd64, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd64, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd2015, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_READ, 11'd2015, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_NOP, 11'd2047, 6'd63, 7'h7f, 32'hffffffff);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd0, 7'd5, 32'h00000001);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd1, 7'h7f, 32'd0);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd2, 7'h7f, 32'd0);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd3, 7'd63, 32'hffffffff);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd63, 7'h40, 32'h80000000);
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd4, 7'd62, 32'h0);
    send_word(bmf_pkg::CMD_READ, 11'd160, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd160, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd161, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd1985, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd1985, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd0, 6'd0, 7'd0, 32'd0);
    wait_drained();

    // Tag blocks 0 to 62 with no spare, then overwrite a page so the overwrite finds no spare.
    send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'd0, 7'd0, 32'h0);
    for (int b = 1; b < 63; b++)
      send_word(bmf_pkg::CMD_SCAN, 11'd0, 6'(b), 7'(b), 32'h0);
    send_word(bmf_pkg::CMD_WRITE, 11'd1999, 6'd0, 7'd0, 32'd0);
    send_word(bmf_pkg::CMD_WRITE, 11'd1999, 6'd0, 7'd0, 32'd0);
    wait_drained();

    // Random phases under different idle patterns; each starts with a mount.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      mount_scan($urandom_range(4, 20));
      random_traffic(45, (ph % 2 == 0) ? 6 : 62);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
